### rtl/wmsd_pkg.sv
// shared types and constants for the windowed motion stop detector
package wmsd_pkg;

  localparam int XW    = 32;
  localparam int TW    = 63;
  localparam int TOLW  = 32;
  localparam int LIMW  = 40;
  localparam int CNTW  = 5;
  localparam int CFGIW = 2;
  localparam int CFGDW = 40;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FAIL   = 2'd1;
  localparam logic [1:0] ST_NOPAIR = 2'd2;

  localparam logic [CFGIW-1:0] CFG_TOL   = 2'd0;
  localparam logic [CFGIW-1:0] CFG_LIMIT = 2'd1;
  localparam logic [CFGIW-1:0] CFG_COUNT = 2'd2;

  localparam logic [TOLW-1:0] TOL_RST   = 32'd100000;
  localparam logic [LIMW-1:0] LIMIT_RST = 40'd2000000000;
  localparam logic [CNTW-1:0] COUNT_RST = 5'd5;

  localparam logic [29:0] NS_PER_S = 30'd1000000000;
  localparam logic [63:0] PAIR_CAP = 64'h0200_0000_0000_0000;

  typedef struct packed {
    logic                 kind;
    logic signed [XW-1:0] pos_x;
    logic signed [XW-1:0] pos_y;
    logic [TW-1:0]        sample_time;
    logic [TW-1:0]        now_time;
  } item_t;

  typedef struct packed {
    logic [TOLW-1:0] tol;
    logic [LIMW-1:0] limit;
    logic [CNTW-1:0] count;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        speed_valid;
    logic [31:0] mean_speed;
    logic        moving;
  } result_t;

  function automatic logic [XW-1:0] abs_diff(input logic signed [XW-1:0] a,
                                             input logic signed [XW-1:0] b);
    logic signed [XW:0] d;
    logic [XW:0]        m;
    d = {a[XW-1], a} - {b[XW-1], b};
    m = d[XW] ? (XW+1)'(-d) : (XW+1)'(d);
    return m[XW-1:0];
  endfunction

endpackage

### rtl/wmsd_ram.sv
// generic single write port ram with registered read
module wmsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

### rtl/wmsd_front.sv
// front end: accepts transactions into a two entry queue
module wmsd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  wmsd_pkg::item_t in_item,
  input  logic            pop,
  output logic            q_valid,
  output wmsd_pkg::item_t q_item
);
  import wmsd_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

### rtl/wmsd_back.sv
// back end: window update, pair speed loop, mean and stop tracking
module wmsd_back #(
  parameter int MAX_WINDOW = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  wmsd_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  wmsd_pkg::item_t   q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output wmsd_pkg::result_t out_res
);
  import wmsd_pkg::*;

  localparam int IW = $clog2(MAX_WINDOW);
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int NW = (CW > CNTW) ? CW : CNTW;
  localparam int EW = 2 * XW + TW;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_RD   = 12'b0000_0000_0010,
    S_WAIT = 12'b0000_0000_0100,
    S_SQ   = 12'b0000_0000_1000,
    S_SUM  = 12'b0000_0001_0000,
    S_SQRT = 12'b0000_0010_0000,
    S_MUL  = 12'b0000_0100_0000,
    S_DIV  = 12'b0000_1000_0000,
    S_ACC  = 12'b0001_0000_0000,
    S_FIN  = 12'b0010_0000_0000,
    S_CMP  = 12'b0100_0000_0000,
    S_OUT  = 12'b1000_0000_0000
  } state_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [TW-1:0]        t;
  } entry_t;

  function automatic logic [IW-1:0] wrap(input logic [IW-1:0] base,
                                         input logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(k);
    if (s >= (CW+1)'(MAX_WINDOW)) s = s - (CW+1)'(MAX_WINDOW);
    return s[IW-1:0];
  endfunction

  state_t  state_r, state_nxt;
  logic [CW-1:0] fill_r, idx_r;
  logic [IW-1:0] oldest_r;
  logic          stopped_r;
  logic [TW-1:0] stop_start_r, last_time_r;
  logic          out_valid_r;
  result_t       out_res_r, res_r;
  item_t         item_r;
  entry_t        prev_r, cur_r, rd_entry;
  logic [EW-1:0] rdata;
  logic [XW-1:0] dx_r, dy_r;
  logic [TW-1:0] dt_r;
  logic [63:0]   sqx_r, sqy_r;
  logic [65:0]   rad_r;
  logic [35:0]   srem_r;
  logic [32:0]   root_r;
  logic [5:0]    cnt_r;
  logic [63:0]   dq_r, drem_r, sum_r;
  logic [TW-1:0] dden_r;
  logic          mean_ph_r, any_r;

  // window bookkeeping for the item at the head of the queue
  logic [NW-1:0] cnt_w;
  logic [CW-1:0] n_c, fill_t, fill_e, fill_n;
  logic [IW-1:0] oldest_t, oldest_e, wslot, raddr;
  logic          ins, evict, we;
  entry_t        wentry;

  // iteration datapath
  logic [37:0]   rem_sh, trial;
  logic [64:0]   dsh;
  logic          qbit;
  logic [62:0]   prod;
  logic [63:0]   sp;
  logic [31:0]   mean;
  logic [TW-1:0] start_t;
  logic          fail, last_pair, out_free;

  always_comb begin
    cnt_w = NW'(cfg.count);
    if (cnt_w < NW'(2))                n_c = CW'(2);
    else if (cnt_w > NW'(MAX_WINDOW))  n_c = CW'(MAX_WINDOW);
    else                               n_c = CW'(cnt_w);
    fill_t   = (fill_r > n_c) ? n_c : fill_r;
    oldest_t = wrap(oldest_r, fill_r - fill_t);
    ins      = (fill_t == '0) || (last_time_r != q_item.sample_time);
    evict    = ins && (fill_t >= n_c);
    oldest_e = evict ? wrap(oldest_t, CW'(1)) : oldest_t;
    fill_e   = evict ? fill_t - CW'(1) : fill_t;
    wslot    = wrap(oldest_e, fill_e);
    fill_n   = ins ? fill_e + CW'(1) : fill_e;
  end

  assign we       = (state_r == S_IDLE) && q_valid && !q_item.kind && ins;
  assign wentry   = '{x: q_item.pos_x, y: q_item.pos_y, t: q_item.sample_time};
  assign raddr    = wrap(oldest_r, idx_r);
  assign rd_entry = entry_t'(rdata);
  assign q_pop    = (state_r == S_IDLE) && q_valid;

  wmsd_ram #(.WIDTH(EW), .DEPTH(MAX_WINDOW)) u_win (
    .clk     (clk),
    .we      (we),
    .waddr   (wslot),
    .wdata   (EW'(wentry)),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  assign rem_sh    = {srem_r, rad_r[65:64]};
  assign trial     = {3'b000, root_r, 2'b01};
  assign dsh       = {drem_r, dq_r[63]};
  assign qbit      = (dsh >= {2'b00, dden_r});
  assign prod      = root_r * NS_PER_S;
  assign sp        = (dq_r > PAIR_CAP) ? PAIR_CAP : dq_r;
  assign mean      = (dq_r[63:32] != '0) ? '1 : dq_r[31:0];
  assign start_t   = stopped_r ? stop_start_r : last_time_r;
  assign fail      = (item_r.now_time > start_t) &&
                     ((item_r.now_time - start_t) > TW'(cfg.limit));
  assign last_pair = (idx_r == fill_r - CW'(1));
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (q_valid) begin
        if (q_item.kind || fill_n < n_c) state_nxt = S_OUT;
        else                             state_nxt = S_RD;
      end
      S_RD:   state_nxt = S_WAIT;
      S_WAIT: begin
        if (idx_r == '0)                     state_nxt = S_RD;
        else if (rd_entry.t > prev_r.t)      state_nxt = S_SQ;
        else if (last_pair)                  state_nxt = S_FIN;
        else                                 state_nxt = S_RD;
      end
      S_SQ:   state_nxt = S_SUM;
      S_SUM:  state_nxt = S_SQRT;
      S_SQRT: if (cnt_r == 6'd32) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_DIV;
      S_DIV:  if (cnt_r == 6'd63) state_nxt = mean_ph_r ? S_CMP : S_ACC;
      S_ACC:  state_nxt = last_pair ? S_FIN : S_RD;
      S_FIN:  state_nxt = any_r ? S_DIV : S_OUT;
      S_CMP:  state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      oldest_r     <= '0;
      stopped_r    <= 1'b0;
      stop_start_r <= '0;
      idx_r        <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: if (q_valid && !q_item.kind) begin
          fill_r   <= fill_n;
          oldest_r <= oldest_e;
          idx_r    <= '0;
        end
        S_WAIT: if (idx_r == '0 || !(rd_entry.t > prev_r.t)) begin
          idx_r <= idx_r + CW'(1);
        end
        S_SUM:  cnt_r <= '0;
        S_SQRT: cnt_r <= (cnt_r == 6'd32) ? '0 : cnt_r + 6'd1;
        S_MUL:  cnt_r <= '0;
        S_DIV:  cnt_r <= cnt_r + 6'd1;
        S_ACC:  idx_r <= idx_r + CW'(1);
        S_FIN:  cnt_r <= '0;
        S_CMP: begin
          if (mean >= cfg.tol) begin
            stopped_r <= 1'b0;
          end else if (!stopped_r) begin
            stopped_r    <= 1'b1;
            stop_start_r <= last_time_r;
          end
        end
        default: ;
      endcase
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: if (q_valid) begin
        item_r <= q_item;
        res_r  <= '0;
        sum_r  <= '0;
        any_r  <= 1'b0;
        if (we) last_time_r <= q_item.sample_time;
      end
      S_WAIT: begin
        cur_r <= rd_entry;
        dx_r  <= abs_diff(rd_entry.x, prev_r.x);
        dy_r  <= abs_diff(rd_entry.y, prev_r.y);
        dt_r  <= rd_entry.t - prev_r.t;
        if (idx_r == '0 || !(rd_entry.t > prev_r.t)) prev_r <= rd_entry;
      end
      S_SQ: begin
        sqx_r <= dx_r * dx_r;
        sqy_r <= dy_r * dy_r;
      end
      S_SUM: begin
        rad_r  <= {1'b0, {1'b0, sqx_r} + {1'b0, sqy_r}};
        srem_r <= '0;
        root_r <= '0;
      end
      S_SQRT: begin
        rad_r <= {rad_r[63:0], 2'b00};
        if (rem_sh >= trial) begin
          srem_r <= 36'(rem_sh - trial);
          root_r <= {root_r[31:0], 1'b1};
        end else begin
          srem_r <= rem_sh[35:0];
          root_r <= {root_r[31:0], 1'b0};
        end
      end
      S_MUL: begin
        dq_r      <= {1'b0, prod};
        drem_r    <= '0;
        dden_r    <= dt_r;
        mean_ph_r <= 1'b0;
      end
      S_DIV: begin
        drem_r <= qbit ? 64'(dsh - {2'b00, dden_r}) : dsh[63:0];
        dq_r   <= {dq_r[62:0], qbit};
      end
      S_ACC: begin
        sum_r  <= sum_r + sp;
        any_r  <= 1'b1;
        prev_r <= cur_r;
      end
      S_FIN: begin
        if (!any_r) res_r.status <= ST_NOPAIR;
        dq_r      <= sum_r;
        drem_r    <= '0;
        dden_r    <= TW'(fill_r - CW'(1));
        mean_ph_r <= 1'b1;
      end
      S_CMP: begin
        res_r.speed_valid <= 1'b1;
        res_r.mean_speed  <= mean;
        if (mean >= cfg.tol) begin
          res_r.moving <= 1'b1;
          res_r.status <= ST_OK;
        end else begin
          res_r.moving <= 1'b0;
          res_r.status <= fail ? ST_FAIL : ST_OK;
        end
      end
      S_OUT: if (out_free) out_res_r <= res_r;
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

### rtl/windowed_motion_stop_detector.sv
// top level of the windowed motion stop detector
// a lookup failure or an unfilled window goes from the queue through S_IDLE and S_OUT
// to the output register; a full window reads each entry and runs every pair with rising
// time through the square root (33 steps) and divider (64 steps), which dominate its run
// throughput: one transaction at a time in the back end; a two entry queue keeps
// accepting while it works and the output register waits on the sink
// reset (rst_n low, synchronous): window empty, stop mark clear, registers to defaults
module windowed_motion_stop_detector #(
  parameter int MAX_WINDOW = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration writes
  input  logic                        cfg_we,
  input  logic [wmsd_pkg::CFGIW-1:0]  cfg_index,
  input  logic [wmsd_pkg::CFGDW-1:0]  cfg_wdata,
  // input transactions
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_kind,
  input  logic signed [31:0]          in_pos_x,
  input  logic signed [31:0]          in_pos_y,
  input  logic [62:0]                 in_sample_time,
  input  logic [62:0]                 in_now_time,
  // result transactions
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic                        out_speed_valid,
  output logic [31:0]                 out_mean_speed,
  output logic                        out_moving
);
  import wmsd_pkg::*;

  cfg_t    cfg_r;
  item_t   in_item, q_item;
  result_t res;
  logic    q_valid, q_pop;

  // configuration registers, to be written only while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tol   <= TOL_RST;
      cfg_r.limit <= LIMIT_RST;
      cfg_r.count <= COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOL:   cfg_r.tol   <= cfg_wdata[TOLW-1:0];
        CFG_LIMIT: cfg_r.limit <= cfg_wdata[LIMW-1:0];
        CFG_COUNT: cfg_r.count <= cfg_wdata[CNTW-1:0];
        default: ;
      endcase
    end
  end

  assign in_item = '{kind: in_kind, pos_x: in_pos_x, pos_y: in_pos_y,
                     sample_time: in_sample_time, now_time: in_now_time};

  // front: queue of accepted transactions
  wmsd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  // back: window, speed evaluation and stop tracking
  wmsd_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_status      = res.status;
  assign out_speed_valid = res.speed_valid;
  assign out_mean_speed  = res.mean_speed;
  assign out_moving      = res.moving;

endmodule

### rtl/wmsd_checker.sv
// port level checks for the windowed motion stop detector
module wmsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic        out_speed_valid,
  input logic [31:0] out_mean_speed,
  input logic        out_moving
);
  import wmsd_pkg::*;

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // moving only comes with a computed speed and plain success
  a_moving: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_moving |-> out_speed_valid && out_status == ST_OK)
    else $error("moving without speed");

  // no speed means zero speed fields
  a_nospeed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_speed_valid |-> out_mean_speed == '0 && !out_moving &&
    out_status != ST_FAIL)
    else $error("speed fields set without speed");

  // no valid pair never carries a speed
  a_nopair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NOPAIR |-> !out_speed_valid)
    else $error("speed with no valid pair");

endmodule

bind windowed_motion_stop_detector wmsd_checker u_wmsd_checker (.*);

### dv/tb_top.sv
// testbench for the windowed motion stop detector: self-checking, random and directed
`timescale 1ns / 1ps

module tb_top;
  import wmsd_pkg::*;

  // bookkeeping of expected results; holds its own copy of the detector state
  class stop_scoreboard;
    logic [31:0] win_x [16];
    logic [31:0] win_y [16];
    logic [63:0] win_t [16];
    int          fill;
    int          oldest;
    bit          stopped;
    logic [63:0] stop_at;
    logic [31:0] tol;
    logic [39:0] limit;
    logic [4:0]  count;
    result_t     expected_q[$];
    int          errors;
    int          mismatches;
    int          seen;
    int          moving_seen;
    int          fail_seen;
    int          nopair_seen;

    function new();
      fill = 0; oldest = 0; stopped = 0; stop_at = '0;
      tol = TOL_RST; limit = LIMIT_RST; count = COUNT_RST;
      errors = 0; mismatches = 0; seen = 0;
      moving_seen = 0; fail_seen = 0; nopair_seen = 0;
    endfunction

    function void write_reg(logic [CFGIW-1:0] idx, logic [CFGDW-1:0] val);
      case (idx)
        CFG_TOL:   tol   = val[TOLW-1:0];
        CFG_LIMIT: limit = val[LIMW-1:0];
        CFG_COUNT: count = val[CNTW-1:0];
        default: ;
      endcase
    endfunction

    // floor square root of a value below 2^66
    function logic [63:0] root(logic [127:0] v);
      logic [63:0]  r;
      logic [63:0]  c;
      logic [127:0] cc;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
        c  = r | (64'd1 << b);
        cc = {64'd0, c} * {64'd0, c};
        if (cc <= v) r = c;
      end
      return r;
    endfunction

    function logic [63:0] span(logic [31:0] a, logic [31:0] b);
      longint d;
      d = longint'($signed(a)) - longint'($signed(b));
      return (d < 0) ? -d : d;
    endfunction

    function result_t predict(item_t it);
      result_t      r;
      int           n;
      int           s;
      int           a;
      int           b;
      bit           any;
      logic [63:0]  t;
      logic [63:0]  now;
      logic [63:0]  dt;
      logic [63:0]  dx;
      logic [63:0]  dy;
      logic [63:0]  sum;
      logic [63:0]  mean;
      logic [127:0] sq;
      logic [127:0] sp;
      r = '0;
      if (it.kind) return r;
      n = (count < 2) ? 2 : (count > 16) ? 16 : count;
      t = {1'b0, it.sample_time};
      now = {1'b0, it.now_time};
      while (fill > n) begin
        oldest = (oldest + 1) % 16;
        fill--;
      end
      // repeated timestamp: sample dropped, evaluation still runs
      if (fill == 0 || win_t[(oldest + fill - 1) % 16] != t) begin
        if (fill >= n) begin
          oldest = (oldest + 1) % 16;
          fill--;
        end
        s = (oldest + fill) % 16;
        win_x[s] = it.pos_x;
        win_y[s] = it.pos_y;
        win_t[s] = t;
        fill++;
      end
      if (fill < n) return r;
      sum = '0;
      any = 0;
      for (int i = 1; i < fill; i++) begin
        a = (oldest + i - 1) % 16;
        b = (oldest + i) % 16;
        if (win_t[b] <= win_t[a]) continue;
        any = 1;
        dt = win_t[b] - win_t[a];
        dx = span(win_x[b], win_x[a]);
        dy = span(win_y[b], win_y[a]);
        sq = {64'd0, dx} * {64'd0, dx} + {64'd0, dy} * {64'd0, dy};
        sp = ({64'd0, root(sq)} * 128'd1000000000) / {64'd0, dt};
        if (sp > {64'd0, PAIR_CAP}) sp = {64'd0, PAIR_CAP};
        sum += sp[63:0];
      end
      if (!any) begin
        r.status = ST_NOPAIR;
        return r;
      end
      mean = sum / (fill - 1);
      if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
      r.speed_valid = 1'b1;
      r.mean_speed = mean[31:0];
      if (mean >= {32'd0, tol}) begin
        stopped = 0;
        r.moving = 1'b1;
        return r;
      end
      if (!stopped) begin
        stop_at = win_t[(oldest + fill - 1) % 16];
        stopped = 1;
      end
      if (now > stop_at && now - stop_at > {24'd0, limit}) r.status = ST_FAIL;
      return r;
    endfunction

    function void note_input(item_t it);
      expected_q.insert(expected_q.size(), predict(it));
    endfunction

    function void check_result(result_t got);
      result_t want;
      seen++;
      if (got.moving) moving_seen++;
      if (got.status == ST_FAIL) fail_seen++;
      if (got.status == ST_NOPAIR) nopair_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("unexpected result transaction: %p", got);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status %0d sv %0b speed %0d mov %0b, got %0d %0b %0d %0b",
                   want.status, want.speed_valid, want.mean_speed, want.moving,
                   got.status, got.speed_valid, got.mean_speed, got.moving);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CFGIW-1:0]   cfg_index = '0;
  logic [CFGDW-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_kind = 1'b0;
  logic signed [31:0] in_pos_x = '0;
  logic signed [31:0] in_pos_y = '0;
  logic [62:0]        in_sample_time = '0;
  logic [62:0]        in_now_time = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic               out_speed_valid;
  logic [31:0]        out_mean_speed;
  logic               out_moving;

  stop_scoreboard sb = new();
  bit  idling = 1'b1;       // random idling on both sides
  bit  sink_hold = 1'b0;    // long receiver hold-off
  int  quiet_cycles = 0;
  int  items_sent = 0;
  localparam int QUIET_LIMIT = 40000;

  // trajectory state for well-formed sequences
  logic [62:0]        cur_t;
  logic signed [31:0] cur_x;
  logic signed [31:0] cur_y;

  windowed_motion_stop_detector i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stall, changed at the falling edge
  always @(negedge clk)
    out_stall <= sink_hold || (idling && $urandom_range(99) < 30);

  // result sampling and watchdog at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_status, out_speed_valid, out_mean_speed, out_moving});
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // offer one input transaction and wait until it is taken
  task automatic send(item_t it);
    while (idling && $urandom_range(99) < 30) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_kind = it.kind;
    in_pos_x = it.pos_x;
    in_pos_y = it.pos_y;
    in_sample_time = it.sample_time;
    in_now_time = it.now_time;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic put(bit k, logic [31:0] x, logic [31:0] y, logic [62:0] t, logic [62:0] now);
    send('{k, x, y, t, now});
  endtask

  // waits for every expectation, then lets the block settle before a register write
  task automatic drain();
    in_valid = 1'b0;
    wait (sb.expected_q.size() == 0);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFGIW-1:0] idx, logic [CFGDW-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [62:0] rand_t63();
    return 63'({$urandom, $urandom});
  endfunction

  // motion with random segments: standing, creeping, moving, plus noise
  task automatic wander(int num, logic [62:0] base);
    int          mode;
    int          seg;
    int          pick;
    item_t       it;
    logic [31:0] step;
    cur_t = base;
    seg = 0;
    mode = 0;
    for (int i = 0; i < num; i++) begin
      if (seg == 0) begin
        mode = $urandom_range(3);
        seg = $urandom_range(4, 30);
      end
      seg--;
      pick = $urandom_range(99);
      case (mode)
        0: step = $urandom_range(3);
        1: step = $urandom_range(500);
        2: step = $urandom_range(20000);
        default: step = $urandom_range(2000000);
      endcase
      if (pick < 6) begin
        // noise over the full field ranges
        it = '{1'($urandom_range(1)), $urandom, $urandom, rand_t63(), rand_t63()};
      end else if (pick < 14) begin
        it = '{1'b1, $urandom, $urandom, rand_t63(), rand_t63()};
      end else begin
        if (pick < 19) ;                                   // repeated timestamp
        else if (pick < 22) cur_t = cur_t - $urandom_range(1, 100000000);
        else cur_t = cur_t + $urandom_range(1, 60000000);
        cur_x = cur_x + $signed(($urandom_range(1)) ? step : -step);
        cur_y = cur_y + $signed(($urandom_range(1)) ? $urandom_range(step) : 0);
        it = '{1'b0, cur_x, cur_y, cur_t,
               ($urandom_range(9) == 0) ? cur_t - $urandom_range(1000)
                                        : cur_t + $urandom_range(0, 32'hC000_0000)};
      end
      send(it);
    end
  endtask

  initial begin
    cur_x = '0;
    cur_y = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // directed part at the reset settings, window of five
    put(1'b1, '1, '1, '1, '1);                         // lookup failure, all ones
    put(1'b0, 32'h8000_0000, 32'h8000_0000, 63'd0, 63'd0);
    put(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 63'd1, 63'd1);  // largest jump
    put(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 63'd1, 63'd5);  // same timestamp
    put(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 63'd2, 63'd5);
    put(1'b0, 32'h8000_0000, 32'h8000_0000, 63'd3, 63'd5);  // window still one short of full
    put(1'b0, 32'd0, 32'd0, 63'd0, 63'd5);                  // time going backwards
    put(1'b0, 32'd0, 32'd0, 63'd0, 63'd5);
    put(1'b0, 32'd0, 32'd0, 63'd1, 63'd5);
    put(1'b0, 32'd0, 32'd0, 63'd0, 63'd5);                  // time going backwards again
    put(1'b0, 32'd0, 32'd0, 63'd1, 63'd5);
    put(1'b0, 32'd10, 32'd0, 63'd1000000000, 63'd1000000000);  // stopped
    put(1'b0, 32'd10, 32'd0, 63'd2000000000, 63'd100);     // still stopped, clock within the limit
    put(1'b0, 32'd10, 32'd0, 63'd3000000000, 63'd3000000001); // limit already exceeded
    put(1'b0, 32'd10, 32'd0, 63'd4000000000, 63'd9000000000); // stopped too long
    put(1'b0, 32'd2000000, 32'd0, 63'd5000000000, 63'd9000000000); // moving again
    put(1'b1, 32'd0, 32'd0, 63'd0, 63'd0);
    put(1'b0, 32'd2000000, 32'd0, '1, '1);                 // largest timestamp
    put(1'b0, 32'd2000000, 32'd0, '1 - 63'd1, 63'd0);
    cur_t = 63'd6000000000;
    cur_x = 32'd2000000;

    // phases across register settings; count 0 and 31 exercise clamping
    drain();
    write_cfg(CFG_TOL, 40'd100000);
    write_cfg(CFG_LIMIT, 40'd1000000000);
    write_cfg(CFG_COUNT, 40'd3);
    idling = 1'b0;                                     // stretch with no idling
    wander(250, 63'd10000000000);
    idling = 1'b1;

    drain();
    write_cfg(CFG_TOL, 40'd0);
    write_cfg(CFG_LIMIT, 40'd0);
    write_cfg(CFG_COUNT, 40'd2);
    fork
      begin
        sink_hold = 1'b1;
        repeat (3000) @(posedge clk);
        sink_hold = 1'b0;
      end
    join_none
    wander(150, 63'h4000_0000_0000_0000);              // high time bits in sequences

    drain();
    write_cfg(CFG_TOL, 40'hFF_FFFF_FFFF);
    write_cfg(CFG_LIMIT, 40'hFF_FFFF_FFFF);
    write_cfg(CFG_COUNT, 40'd16);
    wander(60, 63'd5);

    drain();
    write_cfg(CFG_TOL, 40'd50000);
    write_cfg(CFG_LIMIT, 40'd500000000);
    write_cfg(CFG_COUNT, 40'd0);                       // lowered from sixteen
    wander(150, 63'd777);

    drain();
    write_cfg(CFG_TOL, 40'd20000);
    write_cfg(CFG_LIMIT, 40'd3000000000);
    write_cfg(CFG_COUNT, 40'd4);
    wander(250, 63'h7FFF_FFFF_0000_0000);

    drain();
    write_cfg(CFG_TOL, 40'd200000);
    write_cfg(CFG_LIMIT, 40'd0);
    write_cfg(CFG_COUNT, 40'd31);
    wander(40, 63'd123456789);

    drain();
    write_cfg(CFG_TOL, 40'd100000);
    write_cfg(CFG_LIMIT, 40'd2000000000);
    write_cfg(CFG_COUNT, 40'd5);
    wander(350, 63'd50000000000);

    drain();
    repeat (2000) @(negedge clk);
    if (sb.expected_q.size() != 0) begin
      sb.errors += sb.expected_q.size();
      $display("%0d expected results never arrived", sb.expected_q.size());
    end
    $display("covered %0d input transactions and %0d results over eight register settings",
             items_sent, sb.seen);
    $display("moving %0d, stopped too long %0d, no valid pair %0d, errors %0d",
             sb.moving_seen, sb.fail_seen, sb.nopair_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
